@@ src/gfps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the gRPC first-frame failure scanner.
// No dependencies; imported by the interfaces, the top level and the checker.
package gfps_pkg;

  // Parse phase of the body walker
  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_KEY    = 3'd1,
    PH_VALUE  = 3'd2,
    PH_LEN    = 3'd3,
    PH_SKIP   = 3'd4,
    PH_DONE   = 3'd5,
    PH_TRAIL  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_SUCCESS    = 2'd0,
    ST_REJECTED   = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_COMPRESSED = 2'd3
  } status_t;

  // protobuf wire types that are accepted
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam int unsigned FIELD_W    = 29;
  localparam logic [2:0]  HDR_BYTES  = 3'd5;
  localparam logic [3:0]  VARINT_MAX = 4'd10;
  localparam logic [31:0] FIXED64_LEN = 32'd8;
  localparam logic [31:0] FIXED32_LEN = 32'd4;

  localparam logic [FIELD_W-1:0] FAILURE_FIELD_RST = 29'd2;

  // register index, taken from paddr[2]
  localparam logic REG_FAILURE_FIELD = 1'b0;

endpackage

@@ src/gfps_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the body byte stream and the status result.
// Depends on gfps_pkg.
interface gfps_body_if
  import gfps_pkg::*;
();
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] body_byte;
  logic       last_byte;

  modport source (output valid, has_byte, body_byte, last_byte, input ready);
  modport sink   (input valid, has_byte, body_byte, last_byte, output ready);
endinterface

interface gfps_status_if
  import gfps_pkg::*;
();
  logic    valid;
  logic    ready;
  status_t status;

  modport source (output valid, status, input ready);
  modport sink   (input valid, status, output ready);
endinterface

@@ src/grpc_frame_protobuf_failure_scan_top.sv @@
`timescale 1ns / 1ps
// Top level of the gRPC first-frame failure scanner with its APB register.
// Depends on gfps_pkg and the channel interfaces in gfps_if.sv.
//
//  channel  | dir | payload                          | transfer
//  ---------+-----+----------------------------------+----------------------
//  body     | in  | has_byte, body_byte, last_byte   | valid & ready
//  result   | out | status[1:0]                      | valid & ready
//  apb      | in  | failure_field @ 0x0              | psel & penable & pwrite
//
// One byte is taken per cycle while body.ready is high; the status of a body
// sits in the output register the cycle after its last byte is transferred.
// The parse state updates in one pass from the current byte and state registers.
// body.ready drops only while a byte with last_byte is offered and the
// previous status has not been taken; other bytes flow regardless.
// rst is synchronous: clears the parser, the result and sets failure_field to 2.
module grpc_frame_protobuf_failure_scan_top
  import gfps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  gfps_body_if.sink            body,
  gfps_status_if.source        result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // configuration
  logic [FIELD_W-1:0] failure_field;

  // parse state
  logic [2:0]  header_count, header_count_next;
  logic        compressed_seen, compressed_seen_next;
  logic [31:0] message_left, message_left_next;
  phase_t      parse_phase, parse_phase_next;
  logic [31:0] varint_accum, varint_accum_next;   // low 32 bits of the varint
  logic        varint_high, varint_high_next;     // some bit in [63:32] is set
  logic [3:0]  varint_bytes, varint_bytes_next;
  logic [31:0] skip_left, skip_left_next;
  logic        failure_seen, failure_seen_next;

  // result register
  logic    out_valid;
  status_t out_status;
  status_t status_next;

  logic in_fire, take, cfg_wr;

  // varint step
  logic [6:0]  payload7;
  logic [31:0] ins_low;
  logic        ins_high;
  logic [31:0] acc_upd;
  logic        high_upd;
  logic [3:0]  bytes_upd;
  logic        vi_done, vi_over;
  logic [2:0]  wire_kind;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_FAILURE_FIELD);
  assign prdata  = (paddr[2] == REG_FAILURE_FIELD) ? {3'b000, failure_field} : 32'd0;

  assign body.ready = !out_valid || result.ready || !body.last_byte;
  assign in_fire    = body.valid && body.ready;
  assign take       = in_fire && body.has_byte;

  assign result.valid  = out_valid;
  assign result.status = out_status;

  // place the 7 payload bits of this varint byte; bits past 63 drop out
  assign payload7 = body.body_byte[6:0];
  always_comb begin
    ins_low  = 32'd0;
    ins_high = 1'b0;
    unique case (varint_bytes)
      4'd0: ins_low = {25'd0, payload7};
      4'd1: ins_low = {18'd0, payload7, 7'd0};
      4'd2: ins_low = {11'd0, payload7, 14'd0};
      4'd3: ins_low = {4'd0, payload7, 21'd0};
      4'd4: begin
        ins_low  = {payload7[3:0], 28'd0};
        ins_high = |payload7[6:4];
      end
      4'd5, 4'd6, 4'd7, 4'd8: ins_high = |payload7;
      4'd9: ins_high = payload7[0];
      default: ;
    endcase
  end

  assign acc_upd   = varint_accum | ins_low;
  assign high_upd  = varint_high | ins_high;
  assign bytes_upd = varint_bytes + 4'd1;
  assign vi_done   = !body.body_byte[7];
  assign vi_over   = body.body_byte[7] && (bytes_upd >= VARINT_MAX);
  assign wire_kind = acc_upd[2:0];

  // next-state logic
  always_comb begin
    header_count_next    = header_count;
    compressed_seen_next = compressed_seen;
    message_left_next    = message_left;
    parse_phase_next     = parse_phase;
    varint_accum_next    = varint_accum;
    varint_high_next     = varint_high;
    varint_bytes_next    = varint_bytes;
    skip_left_next       = skip_left;
    failure_seen_next    = failure_seen;

    if (take) begin
      if (parse_phase == PH_HEADER) begin
        if (header_count == 3'd0) begin
          compressed_seen_next = (body.body_byte != 8'd0);
        end else begin
          message_left_next = {message_left[23:0], body.body_byte};
        end
        if (header_count + 3'd1 >= HDR_BYTES) begin
          header_count_next = HDR_BYTES;
          parse_phase_next  = (message_left_next == 32'd0) ? PH_TRAIL : PH_KEY;
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end else if (parse_phase != PH_TRAIL) begin
        message_left_next = message_left - 32'd1;
        unique case (parse_phase)
          PH_KEY, PH_VALUE, PH_LEN: begin
            varint_accum_next = acc_upd;
            varint_high_next  = high_upd;
            varint_bytes_next = bytes_upd;
            if (vi_over) begin
              failure_seen_next = 1'b1;
              parse_phase_next  = PH_DONE;
            end else if (vi_done) begin
              varint_accum_next = 32'd0;
              varint_high_next  = 1'b0;
              varint_bytes_next = 4'd0;
              if (parse_phase == PH_KEY) begin
                if (!high_upd && (acc_upd[31:3] == failure_field)) begin
                  failure_seen_next = 1'b1;
                  parse_phase_next  = PH_DONE;
                end else begin
                  unique case (wire_kind)
                    WT_VARINT: parse_phase_next = PH_VALUE;
                    WT_LEN:    parse_phase_next = PH_LEN;
                    WT_FIXED64: begin
                      skip_left_next   = FIXED64_LEN;
                      parse_phase_next = PH_SKIP;
                    end
                    WT_FIXED32: begin
                      skip_left_next   = FIXED32_LEN;
                      parse_phase_next = PH_SKIP;
                    end
                    default: begin
                      failure_seen_next = 1'b1;
                      parse_phase_next  = PH_DONE;
                    end
                  endcase
                end
              end else if (parse_phase == PH_VALUE) begin
                parse_phase_next = PH_KEY;
              end else begin
                // length prefix must fit in what is left of the message
                if (high_upd || (acc_upd > message_left_next)) begin
                  failure_seen_next = 1'b1;
                  parse_phase_next  = PH_DONE;
                end else begin
                  skip_left_next   = acc_upd;
                  parse_phase_next = (acc_upd == 32'd0) ? PH_KEY : PH_SKIP;
                end
              end
            end
          end
          PH_SKIP: begin
            skip_left_next = skip_left - 32'd1;
            if (skip_left == 32'd1) parse_phase_next = PH_KEY;
          end
          default: ;
        endcase
        // message ended: anything but a clean field boundary is malformed
        if (message_left_next == 32'd0) begin
          if (parse_phase_next != PH_DONE &&
              (parse_phase_next != PH_KEY || varint_bytes_next != 4'd0)) begin
            failure_seen_next = 1'b1;
          end
          parse_phase_next = PH_TRAIL;
        end
      end
    end
  end

  // status of the body as it stands after this byte
  always_comb begin
    if (header_count_next < HDR_BYTES) begin
      status_next = ST_SUCCESS;
    end else if (parse_phase_next != PH_TRAIL) begin
      status_next = ST_INCOMPLETE;
    end else if (compressed_seen_next) begin
      status_next = ST_COMPRESSED;
    end else if (failure_seen_next) begin
      status_next = ST_REJECTED;
    end else begin
      status_next = ST_SUCCESS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      failure_field <= FAILURE_FIELD_RST;
    end else if (cfg_wr) begin
      failure_field <= pwdata[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_fire && body.last_byte)) begin
      header_count    <= 3'd0;
      compressed_seen <= 1'b0;
      message_left    <= 32'd0;
      parse_phase     <= PH_HEADER;
      varint_accum    <= 32'd0;
      varint_high     <= 1'b0;
      varint_bytes    <= 4'd0;
      skip_left       <= 32'd0;
      failure_seen    <= 1'b0;
    end else begin
      header_count    <= header_count_next;
      compressed_seen <= compressed_seen_next;
      message_left    <= message_left_next;
      parse_phase     <= parse_phase_next;
      varint_accum    <= varint_accum_next;
      varint_high     <= varint_high_next;
      varint_bytes    <= varint_bytes_next;
      skip_left       <= skip_left_next;
      failure_seen    <= failure_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && body.last_byte) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && body.last_byte) begin
      out_status <= status_next;
    end
  end

endmodule

@@ src/gfps_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the failure scanner, bound onto the top level.
// Depends on gfps_pkg and grpc_frame_protobuf_failure_scan_top.
module gfps_checker
  import gfps_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    in_valid,
  input logic    in_ready,
  input logic    in_last,
  input logic    out_valid,
  input logic    out_ready,
  input status_t out_status
);

  logic end_fire;
  assign end_fire = in_valid && in_ready && in_last;

  // a pending status holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("status changed or dropped before transfer");

  a_end_gives_status: assert property (@(posedge clk) disable iff (rst)
    end_fire |=> out_valid)
    else $error("end of body without a status");

  a_status_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(end_fire))
    else $error("status without an end of body");

  // an end byte must wait while an older status is unread
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_last |-> !in_ready)
    else $error("end byte taken over an unread status");

  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !end_fire |=> !out_valid)
    else $error("status repeated after transfer");

endmodule

bind grpc_frame_protobuf_failure_scan_top gfps_checker u_gfps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (body.valid),
  .in_ready   (body.ready),
  .in_last    (body.last_byte),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_status (result.status)
);

@@ tb/grpc_frame_protobuf_failure_scan_top_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the gRPC first-frame failure scanner: random and directed bodies,
// a status predictor in a scoreboard class, and APB writes of the failure field.
// Depends on gfps_pkg, gfps_if.sv and grpc_frame_protobuf_failure_scan_top.
import gfps_pkg::*;

class scan_verdicts;
  logic [FIELD_W-1:0] reject_field;
  logic [2:0]  hdr_taken;
  logic        flag_set;
  logic [31:0] body_left;
  phase_t      walk;
  logic [63:0] acc;
  logic [3:0]  acc_bytes;
  logic [2:0]  kind;
  logic [31:0] skip_cnt;
  logic        bad_seen;
  status_t     due_status[$];
  int          mismatches;

  function new();
    reject_field = FAILURE_FIELD_RST;
    mismatches = 0;
    clear_body();
  endfunction

  function void clear_body();
    hdr_taken = '0;
    flag_set  = 1'b0;
    body_left = '0;
    walk      = PH_HEADER;
    acc       = '0;
    acc_bytes = '0;
    kind      = '0;
    skip_cnt  = '0;
    bad_seen  = 1'b0;
  endfunction

  function void mark_bad();
    bad_seen = 1'b1;
    walk = PH_DONE;
  endfunction

  // 1: varint ended, 0: more to come, -1: still going after ten bytes
  function int varint_step(logic [7:0] b);
    if (acc_bytes < VARINT_MAX)
      acc = acc | (64'(b[6:0]) << (7 * int'(acc_bytes)));
    acc_bytes = acc_bytes + 4'd1;
    if (!b[7]) return 1;
    if (acc_bytes >= VARINT_MAX) return -1;
    return 0;
  endfunction

  function void message_byte(logic [7:0] b);
    int r;
    body_left = body_left - 32'd1;
    case (walk)
      PH_KEY: begin
        r = varint_step(b);
        if (r < 0) begin
          mark_bad();
        end else if (r > 0) begin
          kind = acc[2:0];
          if ((acc >> 3) == 64'(reject_field)) begin
            mark_bad();
          end else begin
            acc = '0;
            acc_bytes = '0;
            if (kind == WT_VARINT) walk = PH_VALUE;
            else if (kind == WT_LEN) walk = PH_LEN;
            else if (kind == WT_FIXED64) begin
              skip_cnt = FIXED64_LEN;
              walk = PH_SKIP;
            end else if (kind == WT_FIXED32) begin
              skip_cnt = FIXED32_LEN;
              walk = PH_SKIP;
            end else mark_bad();
          end
        end
      end
      PH_VALUE: begin
        r = varint_step(b);
        if (r < 0) begin
          mark_bad();
        end else if (r > 0) begin
          acc = '0;
          acc_bytes = '0;
          walk = PH_KEY;
        end
      end
      PH_LEN: begin
        r = varint_step(b);
        if (r < 0) begin
          mark_bad();
        end else if (r > 0) begin
          if (acc > {32'd0, body_left}) begin
            mark_bad();
          end else begin
            skip_cnt = acc[31:0];
            acc = '0;
            acc_bytes = '0;
            walk = (skip_cnt == 32'd0) ? PH_KEY : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        skip_cnt = skip_cnt - 32'd1;
        if (skip_cnt == 32'd0) walk = PH_KEY;
      end
      default: ;
    endcase
    // message ran out inside a key or a value
    if (body_left == 32'd0) begin
      if (walk != PH_DONE && (walk != PH_KEY || acc_bytes != 4'd0)) bad_seen = 1'b1;
      walk = PH_TRAIL;
    end
  endfunction

  function void take_byte(logic [7:0] b);
    if (walk == PH_HEADER) begin
      if (hdr_taken == 3'd0) flag_set = (b != 8'h00);
      else body_left = {body_left[23:0], b};
      hdr_taken = hdr_taken + 3'd1;
      if (hdr_taken >= HDR_BYTES) begin
        hdr_taken = HDR_BYTES;
        walk = (body_left == 32'd0) ? PH_TRAIL : PH_KEY;
      end
    end else if (walk != PH_TRAIL) begin
      message_byte(b);
    end
  endfunction

  function void note_body_item(logic has_byte, logic [7:0] b, logic last_byte);
    status_t st;
    if (has_byte) take_byte(b);
    if (!last_byte) return;
    if (hdr_taken < HDR_BYTES) st = ST_SUCCESS;
    else if (walk != PH_TRAIL) st = ST_INCOMPLETE;
    else if (flag_set) st = ST_COMPRESSED;
    else if (bad_seen) st = ST_REJECTED;
    else st = ST_SUCCESS;
    due_status.push_back(st);
    clear_body();
  endfunction

  function void note_error(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function void check_status(status_t got);
    status_t want;
    if (due_status.size() == 0) begin
      note_error($sformatf("status %0d transferred with no body pending", got));
      return;
    end
    want = due_status.pop_front();
    if (got !== want)
      note_error($sformatf("status mismatch: expected %0d got %0d", want, got));
  endfunction
endclass

module grpc_frame_protobuf_failure_scan_top_test;
  localparam int ITEMS_PER_PHASE = 380;
  localparam int NUM_PHASES      = 5;
  localparam int HOLD_CYCLES     = 300;
  localparam int HOLD_AT_A       = 25;
  localparam int HOLD_AT_B       = 70;
  localparam int IDLE_SETTLE     = 8;
  localparam int CYCLE_LIMIT     = 600000;

  // wire types the parser must refuse
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED_6  = 3'd6;
  localparam logic [2:0] WT_RESERVED_7  = 3'd7;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] value;
    logic       last_byte;
  } body_item_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gfps_body_if   body_ch ();
  gfps_status_if status_ch ();

  grpc_frame_protobuf_failure_scan_top DUT (
    .clk     (clk),
    .rst     (rst),
    .body    (body_ch),
    .result  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scan_verdicts       sb;
  logic [FIELD_W-1:0] cur_failure;
  logic [7:0]         msg_q[$];
  logic [7:0]         frame_q[$];
  body_item_t         pend_q[$];
  bit                 send_burst;
  bit                 recv_burst;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap(bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void emit_varint(logic [63:0] v, int pad);
    int n, total, i;
    logic [63:0] rest;
    n = 1;
    rest = v >> 7;
    while (rest != 0) begin
      n++;
      rest = rest >> 7;
    end
    total = n + pad;
    if (total > VARINT_MAX) total = VARINT_MAX;
    for (i = 0; i < total; i++)
      msg_q.push_back({(i < total - 1), 7'(v >> (7 * i))});
  endfunction

  function automatic void push_header(logic [7:0] flag, logic [31:0] len);
    frame_q.push_back(flag);
    frame_q.push_back(len[31:24]);
    frame_q.push_back(len[23:16]);
    frame_q.push_back(len[15:8]);
    frame_q.push_back(len[7:0]);
  endfunction

  function automatic void add_field(bit broken);
    logic [63:0] fnum;
    logic [2:0]  wt;
    logic [2:0]  bad_wt[4];
    int          r, pad, n;
    bad_wt = '{WT_GROUP_START, WT_GROUP_END, WT_RESERVED_6, WT_RESERVED_7};
    r = $urandom_range(0, 15);
    if (r < 3) fnum = 64'(cur_failure);
    else if (r < 5) fnum = 64'(FIELD_W'($urandom));
    else if (r == 5) fnum = {$urandom, $urandom} >> 3;   // wider than the register
    else fnum = 64'($urandom_range(1, 20));
    case ($urandom_range(0, 3))
      0: wt = WT_VARINT;
      1: wt = WT_FIXED64;
      2: wt = WT_LEN;
      default: wt = WT_FIXED32;
    endcase
    pad = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    if (broken) begin
      case ($urandom_range(0, 3))
        0: emit_varint((fnum << 3) | 64'(bad_wt[$urandom_range(0, 3)]), pad);
        1: begin
          // key still continuing at its tenth byte
          repeat (10 + $urandom_range(0, 2)) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
          msg_q.push_back(8'($urandom_range(0, 127)));
        end
        2: begin
          emit_varint((fnum << 3) | 64'(WT_VARINT), 0);
          repeat (10) msg_q.push_back(8'hFF);
          msg_q.push_back(8'h01);
        end
        default: begin
          emit_varint((fnum << 3) | 64'(WT_LEN), 0);
          emit_varint({$urandom, $urandom} | 64'h100, 0);
        end
      endcase
      repeat ($urandom_range(0, 4)) msg_q.push_back(8'($urandom));
      return;
    end
    emit_varint((fnum << 3) | 64'(wt), pad);
    case (wt)
      WT_VARINT: begin
        if ($urandom_range(0, 5) == 0) begin
          // ten-byte varint with junk above bit 63
          repeat (9) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
          msg_q.push_back(8'($urandom_range(0, 127)));
        end else begin
          emit_varint({$urandom, $urandom} >> $urandom_range(0, 64), pad);
        end
      end
      WT_FIXED64: repeat (FIXED64_LEN) msg_q.push_back(8'($urandom));
      WT_FIXED32: repeat (FIXED32_LEN) msg_q.push_back(8'($urandom));
      default: begin
        n = $urandom_range(0, 6);
        emit_varint(64'(n), pad);
        repeat (n) msg_q.push_back(8'($urandom));
      end
    endcase
  endfunction

  function automatic void build_frame(bit broken, bit len_off);
    int          nf, i;
    logic [31:0] decl;
    logic [7:0]  flag;
    msg_q.delete();
    nf = $urandom_range(0, 4);
    for (i = 0; i < nf; i++) add_field(1'b0);
    if (broken) begin
      add_field(1'b1);
      if ($urandom_range(0, 1) == 1) add_field(1'b0);
    end
    decl = msg_q.size();
    if (len_off) begin
      if (msg_q.size() != 0 && $urandom_range(0, 1) == 1)
        decl = $urandom_range(0, msg_q.size() - 1);
      else
        decl = msg_q.size() + $urandom_range(1, 6);
    end
    flag = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    push_header(flag, decl);
    foreach (msg_q[k]) frame_q.push_back(msg_q[k]);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
  endfunction

  function automatic void build_random_body();
    int r;
    r = $urandom_range(0, 99);
    frame_q.delete();
    if (r < 60) build_frame(1'b0, 1'b0);
    else if (r < 70) build_frame(1'b0, 1'b1);
    else if (r < 80) build_frame(1'b1, $urandom_range(0, 3) == 0);
    else if (r < 88) repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
    else if (r < 96) repeat ($urandom_range(1, 16)) frame_q.push_back(8'($urandom));
    else begin
      // length far beyond what the body carries
      push_header(8'h00, $urandom | 32'h100);
      repeat ($urandom_range(0, 8)) frame_q.push_back(8'($urandom));
    end
  endfunction

  // turns frame_q into transfers; a body may close on an empty item
  function automatic void queue_body(bit shaped);
    bit end_empty;
    int i;
    end_empty = (frame_q.size() == 0) || (shaped && $urandom_range(0, 7) == 0);
    for (i = 0; i < frame_q.size(); i++) begin
      if (shaped && $urandom_range(0, 29) == 0)
        pend_q.push_back('{1'b0, 8'($urandom), 1'b0});
      pend_q.push_back('{1'b1, frame_q[i], !end_empty && (i == frame_q.size() - 1)});
    end
    if (end_empty) pend_q.push_back('{1'b0, 8'($urandom), 1'b1});
  endfunction

  task automatic send_item(body_item_t it);
    int gap;
    gap = pick_gap(send_burst);
    if (gap > 0) begin
      body_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    body_ch.valid     = 1'b1;
    body_ch.has_byte  = it.has_byte;
    body_ch.body_byte = it.value;
    body_ch.last_byte = it.last_byte;
    do @(posedge clk); while (!(body_ch.valid && body_ch.ready));
    sb.note_body_item(it.has_byte, it.value, it.last_byte);
    @(negedge clk);
  endtask

  task automatic send_pending(inout int count);
    body_item_t it;
    while (pend_q.size() != 0) begin
      it = pend_q.pop_front();
      send_item(it);
      if (it.has_byte || it.last_byte) count++;
    end
  endtask

  task automatic wait_results_drained();
    body_ch.valid = 1'b0;
    while (sb.due_status.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_failure_field(logic [FIELD_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {REG_FAILURE_FIELD, 2'b00};
    pwdata  = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.reject_field = value;
    cur_failure = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  initial begin : status_sink
    int gap;
    int taken;
    status_ch.ready = 1'b0;
    taken = 0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      // long hold-offs back the block up into the body channel
      if (taken == HOLD_AT_A || taken == HOLD_AT_B) gap = HOLD_CYCLES;
      else gap = pick_gap(recv_burst);
      if (gap > 0) begin
        status_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      status_ch.ready = 1'b1;
      do @(posedge clk); while (!(status_ch.valid && status_ch.ready));
      sb.check_status(status_ch.status);
      taken++;
      if ($urandom_range(0, 9) == 0) recv_burst = !recv_burst;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [FIELD_W-1:0] field_plan[NUM_PHASES];
    int                 sent, p;
    sb = new();
    cur_failure = FAILURE_FIELD_RST;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    rst = 1'b1;
    body_ch.valid     = 1'b0;
    body_ch.has_byte  = 1'b0;
    body_ch.body_byte = 8'h00;
    body_ch.last_byte = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle item, empty body, short body, empty frame, compressed,
    // failure field hit, frame that never completes
    sent = 0;
    pend_q.push_back('{1'b0, 8'hFF, 1'b0});
    frame_q.delete();
    queue_body(1'b0);
    frame_q = {8'hFF, 8'h00};
    queue_body(1'b0);
    frame_q.delete();
    push_header(8'h00, 32'd0);
    queue_body(1'b0);
    frame_q.delete();
    push_header(8'hFF, 32'd0);
    queue_body(1'b0);
    frame_q.delete();
    push_header(8'h00, 32'd2);
    frame_q.push_back(8'({FAILURE_FIELD_RST, WT_VARINT}));
    frame_q.push_back(8'h7F);
    queue_body(1'b0);
    frame_q.delete();
    push_header(8'h00, 32'hFFFF_FFFF);
    queue_body(1'b0);
    send_pending(sent);

    field_plan[0] = FIELD_W'(1);
    field_plan[1] = {FIELD_W{1'b1}};
    field_plan[2] = FIELD_W'($urandom_range(3, 536870910));
    field_plan[3] = FAILURE_FIELD_RST;
    field_plan[4] = FIELD_W'($urandom_range(1, 15));

    for (p = 0; p < NUM_PHASES; p++) begin
      wait_results_drained();
      write_failure_field(field_plan[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        send_burst = ($urandom_range(0, 7) == 0);
        build_random_body();
        queue_body(1'b1);
        send_pending(sent);
        if ($urandom_range(0, 24) == 0) wait_results_drained();
      end
    end
    wait_results_drained();
    repeat (IDLE_SETTLE) @(posedge clk);

    if (sb.mismatches == 0 && sb.due_status.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule

@@ sim.f @@
src/gfps_pkg.sv
src/gfps_if.sv
src/grpc_frame_protobuf_failure_scan_top.sv
src/gfps_checker.sv
tb/grpc_frame_protobuf_failure_scan_top_test.sv
